// ----- hdl/sc2a_pkg.sv -----
// ----------------------------------------------------------------------------
// sc2a_pkg
// shared types, scancode constants and the set-1 key map for the scancode
// decoder
// ----------------------------------------------------------------------------
package sc2a_pkg;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_CHAR      = 4'd1,
    ACT_ENDLINE   = 4'd2,
    ACT_BACKSPACE = 4'd3,
    ACT_UP        = 4'd4,
    ACT_DOWN      = 4'd5,
    ACT_LEFT      = 4'd6,
    ACT_RIGHT     = 4'd7,
    ACT_CAPS      = 4'd8
  } act_t;

  // what a scancode byte means when no extended prefix is pending
  typedef enum logic [3:0] {
    KC_NONE,
    KC_LETTER,
    KC_SYMBOL,
    KC_ENTER,
    KC_BACKSPACE,
    KC_CAPS,
    KC_SHIFT_MAKE,
    KC_SHIFT_BREAK,
    KC_PREFIX
  } kclass_t;

  typedef struct packed {
    kclass_t     kclass;
    logic [6:0]  plain_char;
    logic [6:0]  shift_char;
    act_t        ext_action;  // action when the byte follows a prefix
  } keymap_entry_t;

  typedef struct packed {
    act_t        action;
    logic [6:0]  char_out;
    logic        shift_held;
    logic        caps_on;
  } result_t;

  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_UP          = 8'h48;
  localparam logic [7:0] SC_DOWN        = 8'h50;
  localparam logic [7:0] SC_LEFT        = 8'h4B;
  localparam logic [7:0] SC_RIGHT       = 8'h4D;

  localparam logic [6:0] ASCII_NEWLINE  = 7'h0A;
  localparam logic [6:0] ASCII_CASE_BIT = 7'h20;

  localparam keymap_entry_t KEYMAP_BLANK = '{
    kclass: KC_NONE, plain_char: 7'h00, shift_char: 7'h00, ext_action: ACT_NONE
  };

  function automatic keymap_entry_t mk_letter(input logic [6:0] c);
    keymap_entry_t e;
    e = KEYMAP_BLANK;
    e.kclass     = KC_LETTER;
    e.plain_char = c;
    return e;
  endfunction

  function automatic keymap_entry_t mk_sym(input logic [6:0] p, input logic [6:0] s);
    keymap_entry_t e;
    e = KEYMAP_BLANK;
    e.kclass     = KC_SYMBOL;
    e.plain_char = p;
    e.shift_char = s;
    return e;
  endfunction

  function automatic keymap_entry_t mk_class(input kclass_t k);
    keymap_entry_t e;
    e = KEYMAP_BLANK;
    e.kclass = k;
    return e;
  endfunction

  function automatic keymap_entry_t mk_arrow(input act_t a);
    keymap_entry_t e;
    e = KEYMAP_BLANK;
    e.ext_action = a;
    return e;
  endfunction

  function automatic keymap_entry_t keymap_lookup(input logic [7:0] code);
    keymap_entry_t e;
    unique case (code)
      // letters
      8'h1E: e = mk_letter(7'h61);
      8'h30: e = mk_letter(7'h62);
      8'h2E: e = mk_letter(7'h63);
      8'h20: e = mk_letter(7'h64);
      8'h12: e = mk_letter(7'h65);
      8'h21: e = mk_letter(7'h66);
      8'h22: e = mk_letter(7'h67);
      8'h23: e = mk_letter(7'h68);
      8'h17: e = mk_letter(7'h69);
      8'h24: e = mk_letter(7'h6A);
      8'h25: e = mk_letter(7'h6B);
      8'h26: e = mk_letter(7'h6C);
      8'h32: e = mk_letter(7'h6D);
      8'h31: e = mk_letter(7'h6E);
      8'h18: e = mk_letter(7'h6F);
      8'h19: e = mk_letter(7'h70);
      8'h10: e = mk_letter(7'h71);
      8'h13: e = mk_letter(7'h72);
      8'h1F: e = mk_letter(7'h73);
      8'h14: e = mk_letter(7'h74);
      8'h16: e = mk_letter(7'h75);
      8'h2F: e = mk_letter(7'h76);
      8'h11: e = mk_letter(7'h77);
      8'h2D: e = mk_letter(7'h78);
      8'h15: e = mk_letter(7'h79);
      8'h2C: e = mk_letter(7'h7A);
      // top-row digits, us layout shifted forms
      8'h02: e = mk_sym(7'h31, 7'h21);
      8'h03: e = mk_sym(7'h32, 7'h40);
      8'h04: e = mk_sym(7'h33, 7'h23);
      8'h05: e = mk_sym(7'h34, 7'h24);
      8'h06: e = mk_sym(7'h35, 7'h25);
      8'h07: e = mk_sym(7'h36, 7'h5E);
      8'h08: e = mk_sym(7'h37, 7'h26);
      8'h09: e = mk_sym(7'h38, 7'h2A);
      8'h0A: e = mk_sym(7'h39, 7'h28);
      8'h0B: e = mk_sym(7'h30, 7'h29);
      // symbols and space
      8'h29: e = mk_sym(7'h60, 7'h7E);
      8'h0C: e = mk_sym(7'h2D, 7'h5F);
      8'h0D: e = mk_sym(7'h3D, 7'h2B);
      8'h1A: e = mk_sym(7'h5B, 7'h7B);
      8'h1B: e = mk_sym(7'h5D, 7'h7D);
      8'h2B: e = mk_sym(7'h5C, 7'h7C);
      8'h27: e = mk_sym(7'h3B, 7'h3A);
      8'h39: e = mk_sym(7'h20, 7'h20);
      // control keys
      SC_ENTER:       e = mk_class(KC_ENTER);
      SC_BACKSPACE:   e = mk_class(KC_BACKSPACE);
      SC_CAPS:        e = mk_class(KC_CAPS);
      SC_LSHIFT_MAKE: e = mk_class(KC_SHIFT_MAKE);
      SC_RSHIFT_MAKE: e = mk_class(KC_SHIFT_MAKE);
      SC_LSHIFT_BRK:  e = mk_class(KC_SHIFT_BREAK);
      SC_RSHIFT_BRK:  e = mk_class(KC_SHIFT_BREAK);
      SC_PREFIX:      e = mk_class(KC_PREFIX);
      // extended arrow keys
      SC_UP:          e = mk_arrow(ACT_UP);
      SC_DOWN:        e = mk_arrow(ACT_DOWN);
      SC_LEFT:        e = mk_arrow(ACT_LEFT);
      SC_RIGHT:       e = mk_arrow(ACT_RIGHT);
      default:        e = KEYMAP_BLANK;
    endcase
    return e;
  endfunction

endpackage

// ----- hdl/sc2a_keymap_rom.sv -----
// ----------------------------------------------------------------------------
// sc2a_keymap_rom
// synchronous key map memory, one entry per scancode byte, registered read data
// ----------------------------------------------------------------------------
module sc2a_keymap_rom (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [7:0]              rd_addr,
  output sc2a_pkg::keymap_entry_t rd_data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= sc2a_pkg::keymap_lookup(rd_addr);
    end
  end

endmodule

// ----- hdl/sc2a_flag_unit.sv -----
// ----------------------------------------------------------------------------
// sc2a_flag_unit
// prefix, shift and caps flags; turns a key map entry into a result
// ----------------------------------------------------------------------------
module sc2a_flag_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  sc2a_pkg::keymap_entry_t entry,
  output sc2a_pkg::result_t       result
);

  logic extended_pending, extended_pending_next;
  logic shift_flag, shift_flag_next;
  logic caps_flag, caps_flag_next;

  always_comb begin
    extended_pending_next = extended_pending;
    caps_flag_next        = caps_flag;
    result.action         = sc2a_pkg::ACT_NONE;
    result.char_out       = 7'h00;

    // shift codes count even right after a prefix
    case (entry.kclass)
      sc2a_pkg::KC_SHIFT_MAKE:  shift_flag_next = 1'b1;
      sc2a_pkg::KC_SHIFT_BREAK: shift_flag_next = 1'b0;
      default:                  shift_flag_next = shift_flag;
    endcase

    if (entry.kclass == sc2a_pkg::KC_PREFIX) begin
      extended_pending_next = 1'b1;
    end else if (extended_pending) begin
      extended_pending_next = 1'b0;
      result.action         = entry.ext_action;
    end else begin
      case (entry.kclass)
        sc2a_pkg::KC_ENTER: begin
          if (shift_flag_next) begin
            result.action   = sc2a_pkg::ACT_CHAR;
            result.char_out = sc2a_pkg::ASCII_NEWLINE;
          end else begin
            result.action   = sc2a_pkg::ACT_ENDLINE;
          end
        end
        sc2a_pkg::KC_LETTER: begin
          result.action   = sc2a_pkg::ACT_CHAR;
          result.char_out = (shift_flag_next ^ caps_flag)
                            ? (entry.plain_char & ~sc2a_pkg::ASCII_CASE_BIT)
                            : entry.plain_char;
        end
        sc2a_pkg::KC_SYMBOL: begin
          result.action   = sc2a_pkg::ACT_CHAR;
          result.char_out = shift_flag_next ? entry.shift_char : entry.plain_char;
        end
        sc2a_pkg::KC_BACKSPACE: begin
          result.action = sc2a_pkg::ACT_BACKSPACE;
        end
        sc2a_pkg::KC_CAPS: begin
          caps_flag_next = ~caps_flag;
          result.action  = sc2a_pkg::ACT_CAPS;
        end
        default: begin
          result.action = sc2a_pkg::ACT_NONE;
        end
      endcase
    end

    result.shift_held = shift_flag_next;
    result.caps_on    = caps_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      shift_flag       <= 1'b0;
      caps_flag        <= 1'b0;
    end else if (fire) begin
      extended_pending <= extended_pending_next;
      shift_flag       <= shift_flag_next;
      caps_flag        <= caps_flag_next;
    end
  end

endmodule

// ----- hdl/scancode_to_ascii_decoder.sv -----
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder
// set-1 keyboard scancode to ascii decoder with shift and caps-lock tracking
// ----------------------------------------------------------------------------
// Each scancode byte transfer on the input channel yields exactly one result
// transfer: an action code, an ascii character (zero unless the action is a
// character) and the shift and caps-lock states after that byte. The block
// takes one byte per cycle unless the result channel stalls. A byte goes
// through the synchronous key map memory read into the lookup stage, then the
// flag update into the output register. Results leave in input order. The
// prefix, shift and caps flags change only as a byte leaves the lookup stage,
// so back-to-back bytes always see the flags left by the byte before them.
// Both channels stall independently; a held result stalls the lookup stage,
// which in turn stalls the input, with no loss or duplication.
module scancode_to_ascii_decoder (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] action,
  output logic [6:0] char_out,
  output logic       shift_held,
  output logic       caps_on
);

  // lookup stage holds the registered key map entry
  logic                    lookup_valid;
  sc2a_pkg::keymap_entry_t lookup_entry;

  // output register
  sc2a_pkg::result_t       result_next;
  sc2a_pkg::result_t       result;

  logic out_free;     // output register can take a result this cycle
  logic lookup_fire;  // lookup stage moves into the output register
  logic in_fire;      // input transfer

  assign out_free    = ~out_valid | ~out_stall;
  assign lookup_fire = lookup_valid & out_free;
  assign in_stall    = lookup_valid & ~out_free;
  assign in_fire     = in_valid & ~in_stall;

  // key map read, data held while the lookup stage is stalled
  sc2a_keymap_rom u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (scan_byte),
    .rd_data (lookup_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_valid <= 1'b0;
    end else if (in_fire) begin
      lookup_valid <= 1'b1;
    end else if (lookup_fire) begin
      lookup_valid <= 1'b0;
    end
  end

  // flag state and result forming
  sc2a_flag_unit u_flags (
    .clk    (clk),
    .rst    (rst),
    .fire   (lookup_fire),
    .entry  (lookup_entry),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= lookup_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_fire) begin
      result <= result_next;
    end
  end

  assign action     = result.action;
  assign char_out   = result.char_out;
  assign shift_held = result.shift_held;
  assign caps_on    = result.caps_on;

endmodule
